// ===== rtl/core/agmc_pkg.sv =====
// Shared types and constants of the access gate mode controller.
// Holds the request and result structs, mode encoding and register reset values.
// No dependencies.
package agmc_pkg;

	// Widths of the request and result fields.
	localparam int unsigned UidW = 56;
	localparam int unsigned MsW = 16;
	localparam int unsigned CfgIdxW = 3;

	// Command codes carried by a request.
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_CARD = 2'd1;
	localparam logic [1:0] CMD_ANSWER = 2'd2;

	// Screen codes of a result.
	localparam logic [2:0] SCR_NONE = 3'd0;
	localparam logic [2:0] SCR_HOME = 3'd1;
	localparam logic [2:0] SCR_WAIT_REPLY = 3'd2;
	localparam logic [2:0] SCR_WELCOME = 3'd3;
	localparam logic [2:0] SCR_DENIED = 3'd4;
	localparam logic [2:0] SCR_AWAIT_CARD = 3'd5;
	localparam logic [2:0] SCR_ENROLLED = 3'd6;

	// Publish codes of a result.
	localparam logic [1:0] PUB_NONE = 2'd0;
	localparam logic [1:0] PUB_ACCESS = 2'd1;
	localparam logic [1:0] PUB_ENROLL = 2'd2;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_HOME_REFRESH = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_REPLY_TIMEOUT = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ACCESS_SHOW = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ENROLL_WAIT = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ENROLLED_SHOW = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [MsW-1:0] HOME_REFRESH_RST = 16'd60000;
	localparam logic [MsW-1:0] REPLY_TIMEOUT_RST = 16'd15000;
	localparam logic [MsW-1:0] ACCESS_SHOW_RST = 16'd5000;
	localparam logic [MsW-1:0] ENROLL_WAIT_RST = 16'd10000;
	localparam logic [MsW-1:0] ENROLLED_SHOW_RST = 16'd5000;

	// Gate modes.
	typedef enum logic [2:0] {
		MODE_HOME = 3'd0,
		MODE_REPLY = 3'd1,
		MODE_ACCESS = 3'd2,
		MODE_CARD = 3'd3,
		MODE_ENROLLED = 3'd4
	} mode_t;

	// One request.
	typedef struct packed {
		logic [1:0] command;
		logic [UidW-1:0] card_uid;
		logic authorized;
		logic is_admin;
	} item_t;

	// One result.
	typedef struct packed {
		logic [2:0] screen;
		logic [1:0] publish;
		logic [UidW-1:0] publish_uid;
		logic relay_on;
		logic [2:0] mode;
	} result_t;

	// Time limits held in the configuration registers.
	typedef struct packed {
		logic [MsW-1:0] home_refresh_ms;
		logic [MsW-1:0] reply_timeout_ms;
		logic [MsW-1:0] access_show_ms;
		logic [MsW-1:0] enroll_wait_ms;
		logic [MsW-1:0] enrolled_show_ms;
	} cfg_t;

	// Controller state carried from one request to the next.
	typedef struct packed {
		mode_t mode;
		logic [MsW-1:0] elapsed_ms;
		logic relay;
	} state_t;

endpackage

// ===== rtl/core/agmc_cfg_regs.sv =====
// Configuration register file of the access gate mode controller.
// Depends on agmc_pkg for the register indexes, reset values and cfg_t.
module agmc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [agmc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [agmc_pkg::MsW-1:0]     cfg_data,
	output agmc_pkg::cfg_t               cfg
);
	import agmc_pkg::*;

	cfg_t cfg_q;

	// The register file takes a write in every cycle.
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Decode the index; writes beyond the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_refresh_ms <= HOME_REFRESH_RST;
			cfg_q.reply_timeout_ms <= REPLY_TIMEOUT_RST;
			cfg_q.access_show_ms <= ACCESS_SHOW_RST;
			cfg_q.enroll_wait_ms <= ENROLL_WAIT_RST;
			cfg_q.enrolled_show_ms <= ENROLLED_SHOW_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HOME_REFRESH: cfg_q.home_refresh_ms <= cfg_data;
				REG_REPLY_TIMEOUT: cfg_q.reply_timeout_ms <= cfg_data;
				REG_ACCESS_SHOW: cfg_q.access_show_ms <= cfg_data;
				REG_ENROLL_WAIT: cfg_q.enroll_wait_ms <= cfg_data;
				REG_ENROLLED_SHOW: cfg_q.enrolled_show_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/agmc_step.sv =====
// Next-state and result logic for one request of the gate mode controller.
// Purely combinational; depends on agmc_pkg for the codes and types.
module agmc_step (
	input  agmc_pkg::item_t   item,
	input  agmc_pkg::state_t  state,
	input  agmc_pkg::cfg_t    cfg,
	output agmc_pkg::state_t  state_next,
	output agmc_pkg::result_t result
);
	import agmc_pkg::*;

	logic [MsW-1:0] limit;
	logic [MsW-1:0] elapsed_inc;

	// Time limit of the current mode; home refresh serves any other code.
	always_comb begin
		unique case (state.mode)
			MODE_REPLY: limit = cfg.reply_timeout_ms;
			MODE_ACCESS: limit = cfg.access_show_ms;
			MODE_CARD: limit = cfg.enroll_wait_ms;
			MODE_ENROLLED: limit = cfg.enrolled_show_ms;
			default: limit = cfg.home_refresh_ms;
		endcase
	end

	// Saturating millisecond count.
	assign elapsed_inc = (state.elapsed_ms == '1) ? state.elapsed_ms
		: state.elapsed_ms + MsW'(1);

	// Act on the request.
	always_comb begin
		state_next = state;
		result = '0;
		case (item.command)
			CMD_TICK: begin
				state_next.elapsed_ms = elapsed_inc;
				if (elapsed_inc >= limit) begin
					// Only leaving the access notice switches the relay off.
					if (state.mode == MODE_ACCESS) begin
						state_next.relay = 1'b0;
					end
					state_next.mode = MODE_HOME;
					state_next.elapsed_ms = '0;
					result.screen = SCR_HOME;
				end
			end
			CMD_CARD: begin
				// Cards are only taken at home or while waiting to enrol one.
				if (state.mode == MODE_HOME) begin
					state_next.mode = MODE_REPLY;
					state_next.elapsed_ms = '0;
					result.screen = SCR_WAIT_REPLY;
					result.publish = PUB_ACCESS;
					result.publish_uid = item.card_uid;
				end else if (state.mode == MODE_CARD) begin
					state_next.mode = MODE_ENROLLED;
					state_next.elapsed_ms = '0;
					result.screen = SCR_ENROLLED;
					result.publish = PUB_ENROLL;
					result.publish_uid = item.card_uid;
				end
			end
			CMD_ANSWER: begin
				// An answer is acted on in every mode.
				state_next.elapsed_ms = '0;
				if (item.is_admin) begin
					state_next.mode = MODE_CARD;
					result.screen = SCR_AWAIT_CARD;
				end else if (item.authorized) begin
					state_next.mode = MODE_ACCESS;
					state_next.relay = 1'b1;
					result.screen = SCR_WELCOME;
				end else begin
					state_next.mode = MODE_ACCESS;
					result.screen = SCR_DENIED;
				end
			end
			default: ;
		endcase
		result.relay_on = state_next.relay;
		result.mode = state_next.mode;
	end

endmodule

// ===== rtl/core/access_gate_mode_controller_top.sv =====
// Top level of the access gate mode controller.
// Depends on agmc_pkg, agmc_cfg_regs and agmc_step.
//
// The controller takes one request per clock cycle while it is not stalled and
// gives exactly one result for each. The result is presented from the result
// register after the request has passed through the input register.
// A request is first captured in an input register. The mode, elapsed-time and
// relay state are then updated from it by a single layer of logic, and the
// result is held in an output register.
// A request is stalled only when the input register is full and the result
// register holds a result the consumer is stalling. Configuration writes are
// taken in every cycle and must only be made while no request is in flight.
module access_gate_mode_controller_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  agmc_pkg::item_t              item,
	output logic                         result_valid,
	input  logic                         result_stall,
	output agmc_pkg::result_t            result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [agmc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [agmc_pkg::MsW-1:0]     cfg_data
);
	import agmc_pkg::*;

	cfg_t cfg;
	logic valid_s1;
	item_t item_s1;
	logic valid_s2;
	result_t result_s2;
	state_t state_q;
	state_t state_next;
	result_t step_result;
	logic s2_open;

	agmc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	agmc_step u_step (
		.item       (item_s1),
		.state      (state_q),
		.cfg        (cfg),
		.state_next (state_next),
		.result     (step_result)
	);

	// The result register can load when empty or when its result is taken.
	assign s2_open = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !s2_open;
	assign result_valid = valid_s2;
	assign result = result_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Result register and controller state advance together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q.mode <= MODE_HOME;
			state_q.elapsed_ms <= '1;
			state_q.relay <= 1'b0;
		end else if (s2_open) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_open && valid_s1) begin
			result_s2 <= step_result;
		end
	end

endmodule

// ===== rtl/core/agmc_checker.sv =====
// Port-level checker for the access gate mode controller, bound to its top level.
// Depends on agmc_pkg for the result codes.
module agmc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         result_valid,
	input logic                         result_stall,
	input agmc_pkg::result_t            result
);
	import agmc_pkg::*;

	// A stalled result stays put.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Nothing published means no UID on the wire.
	a_uid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.publish == PUB_NONE |-> result.publish_uid == '0)
		else $error("UID present without a publish");

	// An access request always leaves the gate waiting for a reply.
	a_access_mode: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.publish == PUB_ACCESS
		|-> result.screen == SCR_WAIT_REPLY && result.mode == MODE_REPLY)
		else $error("access request without reply wait");

	// A welcome screen comes with the relay on in the access notice.
	a_welcome_relay: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.screen == SCR_WELCOME
		|-> result.relay_on && result.mode == MODE_ACCESS)
		else $error("welcome without relay on");

endmodule

bind access_gate_mode_controller_top agmc_checker u_agmc_checker (.*);
